// File: design/rgc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Garner RNS reconstruction block.
// No dependencies.
package rgc_pkg;

  localparam int RESIDUE_WIDTH = 32;
  localparam int WIDE_WIDTH    = 2 * RESIDUE_WIDTH;
  localparam int OUT_WIDTH     = 3 * RESIDUE_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int NUM_LANES_A   = 5;

  typedef logic [RESIDUE_WIDTH-1:0] res_t;
  typedef logic [WIDE_WIDTH-1:0]    wide_t;
  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MODULUS_0      = 3'd0;
  localparam cfg_idx_t CFG_MODULUS_1      = 3'd1;
  localparam cfg_idx_t CFG_MODULUS_2      = 3'd2;
  localparam cfg_idx_t CFG_GARNER_CONST_1 = 3'd3;
  localparam cfg_idx_t CFG_GARNER_CONST_2 = 3'd4;

  // Payload that rides alongside the wide reduction chains
  typedef struct packed {
    wide_t x;
    res_t  v2;
    res_t  g2;
  } side_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    res_t r2;
  } res3_t;

  // One restoring step of a remainder: shift in one bit, subtract m if it fits.
  // Needs r < m on entry; keeps r < m.
  function automatic res_t red_step(input res_t r, input logic b, input res_t m);
    logic [RESIDUE_WIDTH:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[RESIDUE_WIDTH-1:0];
  endfunction

  // (v - xr) mod m for v, xr already below m
  function automatic res_t mod_sub(input res_t v, input res_t xr, input res_t m);
    logic [RESIDUE_WIDTH:0] t;
    if (v >= xr) begin
      t = {1'b0, v} - {1'b0, xr};
    end else begin
      t = {1'b0, v} + {1'b0, m} - {1'b0, xr};
    end
    return t[RESIDUE_WIDTH-1:0];
  endfunction

endpackage

// File: design/rgc_in_if.sv
`timescale 1ns / 1ps
// Input channel: three residues per transaction, valid/ready handshake.
// Depends on rgc_pkg.
interface rgc_in_if;
  logic              valid;
  logic              ready;
  rgc_pkg::res_t     residue_0;
  rgc_pkg::res_t     residue_1;
  rgc_pkg::res_t     residue_2;

  modport source(output valid, output residue_0, output residue_1, output residue_2,
                 input ready);
  modport sink(input valid, input residue_0, input residue_1, input residue_2,
               output ready);
endinterface

// File: design/rgc_out_if.sv
`timescale 1ns / 1ps
// Result channel: 96-bit integer as low and high parts, valid/ready handshake.
// Depends on rgc_pkg.
interface rgc_out_if;
  logic               valid;
  logic               ready;
  rgc_pkg::wide_t     value_low;
  rgc_pkg::res_t      value_high;

  modport source(output valid, output value_low, output value_high, input ready);
  modport sink(input valid, input value_low, input value_high, output ready);
endinterface

// File: design/rgc_modpipe.sv
`timescale 1ns / 1ps
// Pipelined 64-bit by 32-bit remainder, one bit per stage, with side payload.
// Depends on rgc_pkg.
module rgc_modpipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  rgc_pkg::wide_t  in_op,
  input  rgc_pkg::side_t  in_side,
  input  rgc_pkg::res_t   modulus,
  output logic            out_vld,
  output rgc_pkg::res_t   out_rem,
  output rgc_pkg::side_t  out_side
);
  import rgc_pkg::*;

  logic  [WIDE_WIDTH-1:0] vld_r;
  res_t                   rem_r  [WIDE_WIDTH];
  res_t                   rem_nxt[WIDE_WIDTH];
  wide_t                  op_r   [WIDE_WIDTH];
  side_t                  side_r [WIDE_WIDTH];

  always_comb begin
    for (int k = 0; k < WIDE_WIDTH; k++) begin
      if (k == 0) begin
        rem_nxt[k] = red_step('0, in_op[WIDE_WIDTH-1], modulus);
      end else begin
        rem_nxt[k] = red_step(rem_r[k-1], op_r[k-1][WIDE_WIDTH-1-k], modulus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[WIDE_WIDTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WIDE_WIDTH; k++) begin
        rem_r[k] <= rem_nxt[k];
        if (k == 0) begin
          op_r[k]   <= in_op;
          side_r[k] <= in_side;
        end else begin
          op_r[k]   <= op_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[WIDE_WIDTH-1];
  assign out_rem  = rem_r[WIDE_WIDTH-1];
  assign out_side = side_r[WIDE_WIDTH-1];

endmodule

// File: design/rns_garner_reconstruct.sv
`timescale 1ns / 1ps
// Garner mixed-radix reconstruction of three residues into a 96-bit integer.
// Throughput one transaction per cycle while results are taken; the whole pipeline
// advances together and holds while a finished result is not taken.
// Remainders are formed one bit per stage (32- and 64-step chains).
// Synchronous active-low reset: moduli to 2, constants to 0, pipeline empty.
// Depends on rgc_pkg, rgc_in_if, rgc_out_if, rgc_modpipe.
module rns_garner_reconstruct (
  input  logic                   clk,
  input  logic                   rst_n,
  rgc_in_if.sink                 in_item,
  rgc_out_if.source              out_item,
  input  logic                   cfg_we,
  input  rgc_pkg::cfg_idx_t      cfg_index,
  input  rgc_pkg::res_t          cfg_data
);
  import rgc_pkg::*;

  res_t  mod0_r, mod1_r, mod2_r, gc1_r, gc2_r;
  wide_t prefix_r;
  logic  en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod0_r <= res_t'(2);
      mod1_r <= res_t'(2);
      mod2_r <= res_t'(2);
      gc1_r  <= '0;
      gc2_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS_0:      mod0_r <= cfg_data;
        CFG_MODULUS_1:      mod1_r <= cfg_data;
        CFG_MODULUS_2:      mod2_r <= cfg_data;
        CFG_GARNER_CONST_1: gc1_r  <= cfg_data;
        CFG_GARNER_CONST_2: gc2_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= wide_t'(mod0_r) * wide_t'(mod1_r);
  end

  logic s_vld_r;
  assign en            = !s_vld_r || out_item.ready;
  assign in_item.ready = en;

  // Chain A: lanes r1, r0, C1 mod m1 and r2, C2 mod m2
  logic [RESIDUE_WIDTH-1:0] a_vld_r;
  res_t  a_rem_r  [RESIDUE_WIDTH][NUM_LANES_A];
  res_t  a_rem_nxt[RESIDUE_WIDTH][NUM_LANES_A];
  res3_t a_src_r  [RESIDUE_WIDTH];
  res3_t in_src;

  assign in_src = '{r0: in_item.residue_0, r1: in_item.residue_1, r2: in_item.residue_2};

  always_comb begin
    res3_t src;
    res_t  ops [NUM_LANES_A];
    res_t  mods[NUM_LANES_A];
    res_t  prev;
    for (int k = 0; k < RESIDUE_WIDTH; k++) begin
      src = (k == 0) ? in_src : a_src_r[(k == 0) ? 0 : k-1];
      ops[0] = src.r1;  mods[0] = mod1_r;
      ops[1] = src.r0;  mods[1] = mod1_r;
      ops[2] = gc1_r;   mods[2] = mod1_r;
      ops[3] = src.r2;  mods[3] = mod2_r;
      ops[4] = gc2_r;   mods[4] = mod2_r;
      for (int l = 0; l < NUM_LANES_A; l++) begin
        prev = (k == 0) ? '0 : a_rem_r[(k == 0) ? 0 : k-1][l];
        a_rem_nxt[k][l] = red_step(prev, ops[l][RESIDUE_WIDTH-1-k], mods[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
    end else if (en) begin
      a_vld_r <= {a_vld_r[RESIDUE_WIDTH-2:0], in_item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RESIDUE_WIDTH; k++) begin
        a_rem_r[k] <= a_rem_nxt[k];
        a_src_r[k] <= (k == 0) ? in_src : a_src_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  localparam int AL = RESIDUE_WIDTH - 1;

  // D1 / P1: first digit product
  logic  d1_vld_r, p1_vld_r;
  res_t  d1_diff_r, d1_g_r;
  side_t d1_side_r, p1_side_r;
  wide_t p1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= a_vld_r[AL];
      p1_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_diff_r <= mod_sub(a_rem_r[AL][0], a_rem_r[AL][1], mod1_r);
      d1_g_r    <= a_rem_r[AL][2];
      d1_side_r <= '{x: wide_t'(a_src_r[AL].r0), v2: a_rem_r[AL][3], g2: a_rem_r[AL][4]};
      p1_prod_r <= wide_t'(d1_diff_r) * wide_t'(d1_g_r);
      p1_side_r <= d1_side_r;
    end
  end

  // Chain B: u1 = prod mod m1
  logic  b_vld;
  res_t  b_rem;
  side_t b_side;

  rgc_modpipe u_chain_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(p1_vld_r), .in_op(p1_prod_r), .in_side(p1_side_r), .modulus(mod1_r),
    .out_vld(b_vld), .out_rem(b_rem), .out_side(b_side)
  );

  // X1 / X2: x = r0 + u1 * m0
  logic  x1_vld_r, x2_vld_r;
  wide_t x1_t_r;
  side_t x1_side_r, x2_side_r;
  res_t  u1;

  assign u1 = (mod1_r == '0) ? '0 : b_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= b_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_t_r    <= wide_t'(u1) * wide_t'(mod0_r);
      x1_side_r <= b_side;
      x2_side_r <= '{x: x1_side_r.x + x1_t_r, v2: x1_side_r.v2, g2: x1_side_r.g2};
    end
  end

  // Chain C: x mod m2
  logic  c_vld;
  res_t  c_rem;
  side_t c_side;

  rgc_modpipe u_chain_c (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(x2_vld_r), .in_op(x2_side_r.x), .in_side(x2_side_r), .modulus(mod2_r),
    .out_vld(c_vld), .out_rem(c_rem), .out_side(c_side)
  );

  // D2 / P2: second digit product
  logic  d2_vld_r, p2_vld_r;
  res_t  d2_diff_r, d2_g_r;
  side_t d2_side_r, p2_side_r;
  wide_t p2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (en) begin
      d2_vld_r <= c_vld;
      p2_vld_r <= d2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_diff_r <= mod_sub(c_side.v2, c_rem, mod2_r);
      d2_g_r    <= c_side.g2;
      d2_side_r <= c_side;
      p2_prod_r <= wide_t'(d2_diff_r) * wide_t'(d2_g_r);
      p2_side_r <= d2_side_r;
    end
  end

  // Chain D: u2 = prod mod m2
  logic  dd_vld;
  res_t  dd_rem;
  side_t dd_side;

  rgc_modpipe u_chain_d (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(p2_vld_r), .in_op(p2_prod_r), .in_side(p2_side_r), .modulus(mod2_r),
    .out_vld(dd_vld), .out_rem(dd_rem), .out_side(dd_side)
  );

  // Q: partial products of u2 * (m0 * m1); S: final sum into output register
  logic  q_vld_r;
  wide_t q_pl_r, q_ph_r, q_x_r;
  res_t  u2;
  logic [OUT_WIDTH-1:0] s_sum;
  logic [OUT_WIDTH-1:0] s_val_r;

  assign u2 = (mod2_r == '0) ? '0 : dd_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (en) begin
      q_vld_r <= dd_vld;
      s_vld_r <= q_vld_r;
    end
  end

  assign s_sum = OUT_WIDTH'(q_x_r) + OUT_WIDTH'(q_pl_r) + {q_ph_r, res_t'(0)};

  always_ff @(posedge clk) begin
    if (en) begin
      q_pl_r  <= wide_t'(u2) * wide_t'(prefix_r[RESIDUE_WIDTH-1:0]);
      q_ph_r  <= wide_t'(u2) * wide_t'(prefix_r[WIDE_WIDTH-1:RESIDUE_WIDTH]);
      q_x_r   <= dd_side.x;
      s_val_r <= s_sum;
    end
  end

  assign out_item.valid      = s_vld_r;
  assign out_item.value_low  = s_val_r[WIDE_WIDTH-1:0];
  assign out_item.value_high = s_val_r[OUT_WIDTH-1:WIDE_WIDTH];

endmodule

// File: dv/rns_garner_reconstruct_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rns_garner_reconstruct: drives residue transactions,
// predicts each 96-bit reconstruction and compares results in order.
// Depends on rgc_pkg, rgc_in_if, rgc_out_if and the block itself.
module rns_garner_reconstruct_test;
  import rgc_pkg::*;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 232;

  typedef struct packed {
    wide_t low;
    res_t  high;
  } crt_value_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  res_t cfg_data;

  rgc_in_if in_item();
  rgc_out_if out_item();

  rns_garner_reconstruct i_dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  res3_t pending_residues[$];
  crt_value_t expected_values[$];
  res_t moduli[3];
  res_t garner_c[3];
  int idle_mode;
  int hold_off;
  int errors;
  int checked;
  int watchdog;
  logic in_fire;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic crt_value_t reconstruct(res3_t r);
    logic [127:0] x, m, v, xr, diff, u, g;
    logic [63:0] prefix;
    res_t rv[3];
    crt_value_t res;
    rv[0] = r.r0;
    rv[1] = r.r1;
    rv[2] = r.r2;
    x = 128'(rv[0]);
    prefix = 64'(moduli[0]);
    for (int i = 1; i < 3; i++) begin
      m = 128'(moduli[i]);
      u = '0;
      if (m != 0) begin
        v = 128'(rv[i]) % m;
        xr = x % m;
        diff = (v + m - xr) % m;
        g = 128'(garner_c[i]) % m;
        u = (diff * g) % m;
      end
      x = (x + u * 128'(prefix)) & {32'd0, {96{1'b1}}};
      prefix = prefix * 64'(moduli[i]);
    end
    res.low = x[63:0];
    res.high = x[95:64];
    return res;
  endfunction

  // inverse of a modulo m, or a random value if none exists
  function automatic res_t mod_inverse(res_t a, res_t m);
    longint t0, t1, r0, r1, q, tmp;
    t0 = 0;
    t1 = 1;
    r0 = longint'(m);
    r1 = longint'(a) % longint'(m);
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return $urandom;
    if (t0 < 0) t0 = t0 + longint'(m);
    return res_t'(t0);
  endfunction

  task automatic write_reg(cfg_idx_t idx, res_t data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= CFG_MODULUS_2) moduli[idx] = data;
    else if (idx <= CFG_GARNER_CONST_2) garner_c[idx - CFG_GARNER_CONST_1 + 1] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_moduli(res_t m0, res_t m1, res_t m2, bit real_consts);
    write_reg(CFG_MODULUS_0, m0);
    write_reg(CFG_MODULUS_1, m1);
    write_reg(CFG_MODULUS_2, m2);
    if (real_consts) begin
      write_reg(CFG_GARNER_CONST_1, (m1 > 1) ? mod_inverse(m0, m1) : res_t'($urandom));
      write_reg(CFG_GARNER_CONST_2, (m2 > 1) ? mod_inverse(res_t'((64'(m0) * m1) % m2), m2)
                                             : res_t'($urandom));
    end
  endtask

  function automatic res_t pick_residue(res_t m);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return (m != 0) ? res_t'($urandom % m) : res_t'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    res3_t r;
    for (int k = 0; k < n; k++) begin
      r.r0 = pick_residue(moduli[0]);
      r.r1 = pick_residue(moduli[1]);
      r.r2 = pick_residue(moduli[2]);
      pending_residues.push_back(r);
    end
  endtask

  task automatic queue_directed();
    pending_residues.push_back('{r0: '0, r1: '0, r2: '0});
    pending_residues.push_back('{r0: '1, r1: '1, r2: '1});
    pending_residues.push_back('{r0: '1, r1: '0, r2: '0});
    pending_residues.push_back('{r0: '0, r1: '1, r2: '0});
    pending_residues.push_back('{r0: '0, r1: '0, r2: '1});
    pending_residues.push_back('{r0: 32'h8000_0000, r1: 32'h7fff_ffff, r2: 32'h5555_5555});
  endtask

  task automatic drain();
    while (pending_residues.size() != 0 || in_item.valid || expected_values.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_item.valid <= 1'b0;
    end else if (!in_item.valid || in_fire) begin
      if (pending_residues.size() != 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 83) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 9))) begin
        res3_t r;
        r = pending_residues.pop_front();
        in_item.valid <= 1'b1;
        in_item.residue_0 <= r.r0;
        in_item.residue_1 <= r.r1;
        in_item.residue_2 <= r.r2;
      end else begin
        in_item.valid <= 1'b0;
      end
    end
  end

  // result receiver ready, with a counted long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_item.ready <= 1'b0;
    end else begin
      out_item.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 83) ||
                          (idle_mode == IDLE_BOTH && $urandom_range(99) < 9));
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    crt_value_t exp_v;
    logic any_fire;
    int err_cnt;
    in_fire <= rst_n && in_item.valid && in_item.ready;
    if (rst_n) begin
      any_fire = 1'b0;
      err_cnt = 0;
      if (in_item.valid && in_item.ready) begin
        expected_values.push_back(reconstruct('{r0: in_item.residue_0,
            r1: in_item.residue_1, r2: in_item.residue_2}));
        any_fire = 1'b1;
      end
      if (out_item.valid && out_item.ready) begin
        any_fire = 1'b1;
        checked <= checked + 1;
        if (expected_values.size() == 0) begin
          $error("unexpected result transaction low=%h high=%h",
                 out_item.value_low, out_item.value_high);
          err_cnt++;
        end else begin
          exp_v = expected_values.pop_front();
          if (out_item.value_low !== exp_v.low) begin
            $error("value_low expected %h actual %h", exp_v.low, out_item.value_low);
            err_cnt++;
          end
          if (out_item.value_high !== exp_v.high) begin
            $error("value_high expected %h actual %h", exp_v.high, out_item.value_high);
            err_cnt++;
          end
        end
      end
      if (err_cnt != 0) errors <= errors + err_cnt;
      if (any_fire) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_values.size());
        $display("rns_garner_reconstruct_test: errors");
        $finish;
      end
    end
  end

  initial begin
    res_t m0, m1, m2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODULUS_0;
    cfg_data = '0;
    in_item.valid = 1'b0;
    in_item.residue_0 = '0;
    in_item.residue_1 = '0;
    in_item.residue_2 = '0;
    out_item.ready = 1'b0;
    in_fire = 1'b0;
    idle_mode = IDLE_NONE;
    hold_off = 0;
    errors = 0;
    checked = 0;
    watchdog = 0;
    for (int i = 0; i < 3; i++) begin
      moduli[i] = 32'd2;
      garner_c[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: all moduli two, constants zero
    queue_directed();
    drain();

    // maximum values everywhere; out-of-range indexes must be ignored
    set_moduli('1, '1, '1, 1'b0);
    write_reg(CFG_GARNER_CONST_1, '1);
    write_reg(CFG_GARNER_CONST_2, '1);
    for (int k = 1; k <= 3; k++) write_reg(cfg_idx_t'(CFG_GARNER_CONST_2 + k), 32'h1234_5678);
    queue_directed();
    drain();

    // zero and one moduli, unreduced residues
    set_moduli(32'd0, 32'd1, 32'd7, 1'b1);
    queue_directed();
    drain();
    set_moduli(32'd3, 32'd0, 32'd1, 1'b1);
    queue_directed();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      m0 = $urandom | 32'h1;
      m1 = $urandom | 32'h1;
      m2 = $urandom | 32'h1;
      set_moduli(m0, m1, m2, 1'b1);
      idle_mode = phase;
      // receiver blocks long enough that the pipeline fills and backs up input
      if (phase == IDLE_NONE) hold_off = 3 * LATENCY;
      queue_random((phase == IDLE_NONE) ? 300 : 75);
      drain();
    end

    set_moduli(32'd2, 32'd3, 32'd5, 1'b1);
    idle_mode = IDLE_BOTH;
    queue_random(60);
    drain();

    repeat (LATENCY) @(posedge clk);
    $display("checked %0d reconstructions over default, extreme, degenerate and random",
             checked);
    $display("moduli settings under all idle modes and a long receiver hold-off");
    if (errors == 0 && expected_values.size() == 0) begin
      $display("rns_garner_reconstruct_test: clean");
    end else begin
      $display("rns_garner_reconstruct_test: errors");
    end
    $finish;
  end
endmodule

// File: rns_garner_reconstruct.f
design/rgc_pkg.sv
design/rgc_in_if.sv
design/rgc_out_if.sv
design/rgc_modpipe.sv
design/rns_garner_reconstruct.sv
dv/rns_garner_reconstruct_test.sv
